// ----- src/mrbim_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrbim_pkg
// shared types and constants for the multi-reader buffer index manager
// ----------------------------------------------------------------------------
package mrbim_pkg;

	localparam int READER_SLOTS = 8;
	localparam int NBUF_MAX    = READER_SLOTS + 2;
	localparam int SLOT_W      = 3;
	localparam int LIM_W       = 4;
	localparam int BUF_W       = 4;
	localparam int STATUS_W    = 4;
	localparam int OP_W        = 3;

	localparam logic [BUF_W-1:0] NO_BUF = '1;

	typedef enum logic [OP_W-1:0] {
		OP_WRITER_GET    = 3'd0,
		OP_WRITER_COMMIT = 3'd1,
		OP_READER_ATTACH = 3'd2,
		OP_READER_REL    = 3'd3,
		OP_READER_GET    = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 4'd0,
		STAT_NEW     = 4'd1,
		STAT_OLD     = 4'd2,
		STAT_NODATA  = 4'd3,
		STAT_NOPEND  = 4'd4,
		STAT_FULL    = 4'd5,
		STAT_NOSLOT  = 4'd6,
		STAT_NOBUF   = 4'd7,
		STAT_BADSLOT = 4'd8
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_END,
		S_GET_RD,
		S_FIN
	} state_t;

	typedef struct packed {
		logic             found;
		logic [BUF_W-1:0] idx;
	} pick_t;

endpackage

// ----- src/mrbim_free_pick.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrbim_free_pick
// picks the highest-numbered buffer that is neither latest nor held
// ----------------------------------------------------------------------------
module mrbim_free_pick import mrbim_pkg::*; (
	input  logic [NBUF_MAX-1:0] used,
	input  logic [BUF_W-1:0]    nbuf,
	input  logic                latest_valid,
	input  logic [BUF_W-1:0]    latest_buffer,
	output pick_t               pick
);

	always_comb begin
		pick.found = 1'b0;
		pick.idx   = '0;
		// last match wins, so the highest free buffer is taken
		for (int i = 0; i < NBUF_MAX; i++) begin
			if (BUF_W'(i) < nbuf && !used[i]
					&& !(latest_valid && latest_buffer == BUF_W'(i))) begin
				pick.found = 1'b1;
				pick.idx   = BUF_W'(i);
			end
		end
	end

endmodule

// ----- src/multi_reader_buffer_index_manager.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_reader_buffer_index_manager
// buffer index manager for one writer and several readers
// ----------------------------------------------------------------------------
// latency from accept to result follows the states: writer_get passes S_SCAN
// (one held buffer memory read per reader slot), S_SCAN_END and S_FIN;
// reader_get passes S_GET_RD and S_FIN (only S_FIN for a slot beyond the limit);
// other ops go straight to S_FIN. one item is in work at a time; the next is
// taken once the result register is loaded, and S_FIN waits at a stalled output.
// reset clears control state; unwritten held entries read as none via valid bits
module multi_reader_buffer_index_manager import mrbim_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OP_W-1:0]     opcode,
	input  logic [SLOT_W-1:0]   reader_slot,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [BUF_W-1:0]    buffer_index,
	output logic [SLOT_W-1:0]   reader_slot_out,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [LIM_W-1:0]    cfg_data
);

	state_t state_q, state_d;

	logic [LIM_W-1:0]       reader_limit_q;
	logic [LIM_W-1:0]       lim;
	logic [BUF_W-1:0]       nbuf;
	op_t                    op_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [LIM_W-1:0]       scan_idx_q;
	logic [NBUF_MAX-1:0]    used_q;
	logic [BUF_W-1:0]       latest_q;
	logic                   latest_valid_q;
	logic [BUF_W-1:0]       pending_q;
	logic [READER_SLOTS-1:0] slot_used_q;
	logic [READER_SLOTS-1:0] held_valid_q;
	logic [LIM_W-1:0]       reader_count_q;

	logic [BUF_W-1:0]       held_mem [READER_SLOTS];
	logic                   rd_en;
	logic [SLOT_W-1:0]      rd_addr;
	logic [BUF_W-1:0]       rdata_s1;
	logic                   hv_s1;
	logic                   rd_pend_s1;
	logic [BUF_W-1:0]       held_rd;

	logic                   accept;
	logic                   out_free;
	logic                   fin_fire;
	pick_t                  pick;

	status_t                res_status;
	logic [BUF_W-1:0]       res_bidx;
	logic [SLOT_W-1:0]      res_sout;
	logic                   attach_found;
	logic [SLOT_W-1:0]      attach_slot;
	logic                   slot_ok;

	logic                   out_valid_q;
	logic [STATUS_W-1:0]    status_q;
	logic [BUF_W-1:0]       bidx_q;
	logic [SLOT_W-1:0]      sout_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign fin_fire  = (state_q == S_FIN) && out_free;

	always_comb begin
		if (reader_limit_q == '0) begin
			lim = LIM_W'(1);
		end else if (reader_limit_q > LIM_W'(READER_SLOTS)) begin
			lim = LIM_W'(READER_SLOTS);
		end else begin
			lim = reader_limit_q;
		end
	end

	assign nbuf    = BUF_W'(lim) + BUF_W'(2);
	assign slot_ok = LIM_W'(slot_q) < lim;

	// held buffer memory, one read per cycle
	assign rd_en   = (state_q == S_SCAN) || (state_q == S_GET_RD);
	assign rd_addr = (state_q == S_SCAN) ? scan_idx_q[SLOT_W-1:0] : slot_q;
	assign held_rd = hv_s1 ? rdata_s1 : NO_BUF;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= held_mem[rd_addr];
			hv_s1    <= held_valid_q[rd_addr];
		end
		if (fin_fire && op_q == OP_READER_GET && res_status == STAT_NEW) begin
			held_mem[slot_q] <= latest_q;
		end
	end

	mrbim_free_pick u_pick (
		.used          (used_q),
		.nbuf          (nbuf),
		.latest_valid  (latest_valid_q),
		.latest_buffer (latest_q),
		.pick          (pick)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op_t'(opcode))
						OP_WRITER_GET: state_d = S_SCAN;
						OP_READER_GET: begin
							state_d = (LIM_W'(reader_slot) < lim) ? S_GET_RD : S_FIN;
						end
						default: state_d = S_FIN;
					endcase
				end
			end
			S_SCAN: begin
				if (scan_idx_q == lim - LIM_W'(1)) begin
					state_d = S_SCAN_END;
				end
			end
			S_SCAN_END: state_d = S_FIN;
			S_GET_RD:   state_d = S_FIN;
			S_FIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// lowest free slot below the limit
	always_comb begin
		attach_found = 1'b0;
		attach_slot  = '0;
		for (int i = READER_SLOTS - 1; i >= 0; i--) begin
			if (LIM_W'(i) < lim && !slot_used_q[i]) begin
				attach_found = 1'b1;
				attach_slot  = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		res_status = STAT_OK;
		res_bidx   = '0;
		res_sout   = '0;
		case (op_q)
			OP_WRITER_GET: begin
				if (pick.found) begin
					res_bidx = pick.idx;
				end else begin
					res_status = STAT_NOBUF;
				end
			end
			OP_WRITER_COMMIT: begin
				if (pending_q == NO_BUF) begin
					res_status = STAT_NOPEND;
				end else begin
					res_bidx = pending_q;
				end
			end
			OP_READER_ATTACH: begin
				if (reader_count_q >= lim) begin
					res_status = STAT_FULL;
				end else if (!attach_found) begin
					res_status = STAT_NOSLOT;
				end else begin
					res_sout = attach_slot;
				end
			end
			OP_READER_REL: begin
				if (!slot_ok || !slot_used_q[slot_q]) begin
					res_status = STAT_BADSLOT;
				end
			end
			OP_READER_GET: begin
				if (!slot_ok) begin
					res_status = STAT_BADSLOT;
				end else if (!latest_valid_q || latest_q >= nbuf) begin
					res_status = STAT_NODATA;
				end else begin
					res_status = (held_rd == latest_q) ? STAT_OLD : STAT_NEW;
					res_bidx   = latest_q;
				end
			end
			default: begin
				res_status = STAT_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reader_limit_q <= LIM_W'(READER_SLOTS);
			op_q           <= OP_WRITER_GET;
			slot_q         <= '0;
			scan_idx_q     <= '0;
			used_q         <= '0;
			rd_pend_s1     <= 1'b0;
			latest_q       <= '0;
			latest_valid_q <= 1'b0;
			pending_q      <= NO_BUF;
			slot_used_q    <= '0;
			held_valid_q   <= '0;
			reader_count_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				reader_limit_q <= cfg_data;
			end
			rd_pend_s1 <= (state_q == S_SCAN);
			if (accept) begin
				op_q       <= op_t'(opcode);
				slot_q     <= reader_slot;
				scan_idx_q <= '0;
				used_q     <= '0;
			end
			if (state_q == S_SCAN) begin
				scan_idx_q <= scan_idx_q + LIM_W'(1);
			end
			// mark buffers held by scanned slots
			if (rd_pend_s1) begin
				for (int i = 0; i < NBUF_MAX; i++) begin
					if (held_rd == BUF_W'(i) && held_rd < nbuf) begin
						used_q[i] <= 1'b1;
					end
				end
			end
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (fin_fire) begin
				case (op_q)
					OP_WRITER_GET: begin
						pending_q <= pick.found ? pick.idx : NO_BUF;
					end
					OP_WRITER_COMMIT: begin
						if (pending_q != NO_BUF) begin
							latest_q       <= pending_q;
							latest_valid_q <= 1'b1;
							pending_q      <= NO_BUF;
						end
					end
					OP_READER_ATTACH: begin
						if (res_status == STAT_OK) begin
							slot_used_q[attach_slot] <= 1'b1;
							reader_count_q           <= reader_count_q + LIM_W'(1);
						end
					end
					OP_READER_REL: begin
						if (res_status == STAT_OK) begin
							slot_used_q[slot_q] <= 1'b0;
							if (reader_count_q != '0) begin
								reader_count_q <= reader_count_q - LIM_W'(1);
							end
						end
					end
					OP_READER_GET: begin
						if (res_status == STAT_NEW) begin
							held_valid_q[slot_q] <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			status_q <= res_status;
			bidx_q   <= res_bidx;
			sout_q   <= res_sout;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign buffer_index    = bidx_q;
	assign reader_slot_out = sout_q;

endmodule

// ----- src/mrbim_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrbim_checker
// port-level checks on the buffer index manager, bound to the top level
// ----------------------------------------------------------------------------
module mrbim_checker import mrbim_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [STATUS_W-1:0] status,
	input logic [BUF_W-1:0]    buffer_index,
	input logic [SLOT_W-1:0]   reader_slot_out
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(buffer_index) && $stable(reader_slot_out))
		else $error("stalled result changed");

	// one item in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after an accept");

	// a granted slot only comes with an ok status
	a_slot_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reader_slot_out != '0 |-> status == STAT_OK)
		else $error("slot reported without ok status");

	// error and no-data results carry no buffer
	a_no_buf_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_NODATA || status == STAT_NOPEND
			|| status == STAT_FULL || status == STAT_NOSLOT
			|| status == STAT_NOBUF || status == STAT_BADSLOT)
		|-> buffer_index == '0)
		else $error("buffer index on a result without a buffer");

	// buffer index never beyond the largest buffer
	a_buf_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> buffer_index < BUF_W'(NBUF_MAX))
		else $error("buffer index out of range");

endmodule

bind multi_reader_buffer_index_manager mrbim_checker u_mrbim_checker (.*);
